### hdl/assert_macros.svh
// Assertion macros used by the system registers unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MMSR_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define MMSR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hdl/mmsr_pkg.sv
// ----------------------------------------------------------------------------
// mmsr_pkg
// Types and codes of the move machine system register block: word layouts,
// function codes, register addresses, ALU op codes and fault codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsr_pkg;

  typedef logic [1:0]  func_t;
  typedef logic [2:0]  fault_t;
  typedef logic [15:0] word16_t;

  localparam func_t FUNC_READ  = 2'd0;
  localparam func_t FUNC_WRITE = 2'd1;
  localparam func_t FUNC_INC   = 2'd2;
  localparam func_t FUNC_END   = 2'd3;

  localparam word16_t ADDR_OP       = 16'hfffa;
  localparam word16_t ADDR_A        = 16'hfffb;
  localparam word16_t ADDR_B        = 16'hfffc;
  localparam word16_t ADDR_RESULT   = 16'hfffd;
  localparam word16_t ADDR_PC_SEL   = 16'hffff;
  localparam word16_t ADDR_PC_OTHER = 16'hfffe;
  localparam word16_t ADDR_PAGE_LEN = 16'hfff1;
  localparam word16_t ADDR_PAGE_SRC = 16'hfff0;

  localparam word16_t OP_ADD = 16'd0;
  localparam word16_t OP_GT  = 16'd1;
  localparam word16_t OP_EQ  = 16'd2;
  localparam word16_t OP_LT  = 16'd3;
  localparam word16_t OP_AND = 16'd4;
  localparam word16_t OP_NOT = 16'd5;
  localparam word16_t OP_OR  = 16'd6;
  localparam word16_t OP_SUB = 16'd32;

  localparam fault_t FAULT_NONE       = 3'd0;
  localparam fault_t FAULT_RESULT_WR  = 3'd1;
  localparam fault_t FAULT_BAD_OP     = 3'd2;
  localparam fault_t FAULT_UNDERFLOW  = 3'd3;
  localparam fault_t FAULT_ODD_PC     = 3'd4;
  localparam fault_t FAULT_BLANK_MOVE = 3'd5;

  localparam logic [1:0] BLANK_LIMIT = 2'd3;

  typedef struct packed {
    func_t   func;
    word16_t address;
    word16_t data;
    logic    irq_pending;
    word16_t move_source;
    word16_t move_dest;
  } item_t;

  typedef struct packed {
    word16_t read_data;
    logic    read_valid;
    word16_t mapped_address;
    logic    blocked;
    fault_t  fault;
    word16_t current_pc;
    logic    in_interrupt;
  } result_t;

endpackage

`default_nettype wire

### hdl/move_machine_system_registers_unit.sv
// ----------------------------------------------------------------------------
// move_machine_system_registers_unit
// ALU, program counters and bus firewall of a move-only CPU, one word in,
// one result word out.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result word per word. The word
// lands in an input register at the accepting edge. Once the result register
// is empty or being taken, a single pass of decode, ALU and firewall logic
// updates the system registers and fills the result register, from which
// the result word is offered. The input register advances whenever the
// result register is empty or being taken, so full rate holds as long as
// the consumer keeps result_ready high; a stalled result holds the input
// register behind it.
`default_nettype none

module move_machine_system_registers_unit
  import mmsr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

`include "assert_macros.svh"

  // input stage
  logic    stage_valid;
  item_t   stage;
  logic    advance;
  logic    result_free;

  // system registers
  word16_t operand_a, operand_b, alu_op;
  word16_t main_pc, irq_pc, irq_start;
  logic    irq_context;
  word16_t page_length, page_source;
  logic    guard_on_main, guard_on_irq;
  logic [1:0] blank_count;

  word16_t operand_a_next, operand_b_next, alu_op_next;
  word16_t main_pc_next, irq_pc_next, irq_start_next;
  logic    irq_context_next;
  word16_t page_length_next, page_source_next;
  logic    guard_on_main_next, guard_on_irq_next;
  logic [1:0] blank_count_next;

  result_t res_next;
  word16_t alu_res;
  fault_t  alu_fault;
  logic    guard;
  logic    remapped;
  word16_t sel_pc;
  word16_t other_pc;

  assign result_free = !result_valid || result_ready;
  assign advance     = stage_valid && result_free;
  assign item_ready  = !stage_valid || result_free;

  assign sel_pc   = irq_context ? irq_pc : main_pc;
  assign other_pc = irq_context ? main_pc : irq_pc;
  assign guard    = irq_context ? guard_on_irq : guard_on_main;

  always_comb begin
    alu_res   = '0;
    alu_fault = FAULT_NONE;
    unique case (alu_op)
      OP_ADD: alu_res = operand_a + operand_b;
      OP_GT:  alu_res = {15'd0, operand_a > operand_b};
      OP_EQ:  alu_res = {15'd0, operand_a == operand_b};
      OP_LT:  alu_res = {15'd0, operand_a < operand_b};
      OP_AND: alu_res = operand_a & operand_b;
      OP_NOT: alu_res = ~operand_a;
      OP_OR:  alu_res = operand_a | operand_b;
      OP_SUB: begin
        alu_res = operand_a - operand_b;
        if (operand_a < operand_b) alu_fault = FAULT_UNDERFLOW;
      end
      default: alu_fault = FAULT_BAD_OP;
    endcase
  end

  always_comb begin
    operand_a_next     = operand_a;
    operand_b_next     = operand_b;
    alu_op_next        = alu_op;
    main_pc_next       = main_pc;
    irq_pc_next        = irq_pc;
    irq_start_next     = irq_start;
    irq_context_next   = irq_context;
    page_length_next   = page_length;
    page_source_next   = page_source;
    guard_on_main_next = guard_on_main;
    guard_on_irq_next  = guard_on_irq;
    blank_count_next   = blank_count;
    remapped           = 1'b0;
    res_next           = '0;

    unique case (stage.func)
      FUNC_READ, FUNC_WRITE: begin
        res_next.mapped_address = stage.address;
        // ALU decodes the raw address, ahead of the firewall
        if (stage.func == FUNC_READ) begin
          if (stage.address == ADDR_A) begin
            res_next.read_data  = operand_a;
            res_next.read_valid = 1'b1;
          end else if (stage.address == ADDR_B) begin
            res_next.read_data  = operand_b;
            res_next.read_valid = 1'b1;
          end else if (stage.address == ADDR_OP) begin
            res_next.read_data  = alu_op;
            res_next.read_valid = 1'b1;
          end else if (stage.address == ADDR_RESULT) begin
            res_next.read_data  = alu_res;
            res_next.read_valid = 1'b1;
            res_next.fault      = alu_fault;
          end
        end else begin
          if (stage.address == ADDR_A) operand_a_next = stage.data;
          else if (stage.address == ADDR_B) operand_b_next = stage.data;
          else if (stage.address == ADDR_OP) alu_op_next = stage.data;
          else if (stage.address == ADDR_RESULT) res_next.fault = FAULT_RESULT_WR;
        end

        // firewall: remap inside the page, block everything else but the PC
        if (guard && stage.address != ADDR_PC_SEL) begin
          if (stage.address < page_length) begin
            res_next.mapped_address = stage.address + page_source;
            remapped = 1'b1;
          end else begin
            res_next.blocked = 1'b1;
          end
        end

        if (!res_next.blocked && !remapped) begin
          if (stage.func == FUNC_READ) begin
            if (!res_next.read_valid && stage.address == ADDR_PAGE_LEN) begin
              res_next.read_data  = page_length;
              res_next.read_valid = 1'b1;
            end else if (!res_next.read_valid && stage.address == ADDR_PAGE_SRC) begin
              res_next.read_data  = page_source;
              res_next.read_valid = 1'b1;
            end
          end else begin
            if (stage.address == ADDR_PC_SEL && stage.data == '0) begin
              if (irq_context) guard_on_irq_next = !guard_on_irq;
              else guard_on_main_next = !guard_on_main;
            end
            if (stage.address == ADDR_PAGE_LEN) page_length_next = stage.data;
            else if (stage.address == ADDR_PAGE_SRC) page_source_next = stage.data;
          end
        end

        // program counters see the address as the firewall leaves it
        if (!res_next.blocked) begin
          if (stage.func == FUNC_READ) begin
            if (!res_next.read_valid && res_next.mapped_address == ADDR_PC_SEL) begin
              res_next.read_data  = sel_pc;
              res_next.read_valid = 1'b1;
            end else if (!res_next.read_valid &&
                         res_next.mapped_address == ADDR_PC_OTHER) begin
              res_next.read_data  = other_pc;
              res_next.read_valid = 1'b1;
            end
          end else begin
            if (res_next.mapped_address == ADDR_PC_SEL) begin
              if (irq_context) irq_pc_next = stage.data;
              else main_pc_next = stage.data;
            end else if (res_next.mapped_address == ADDR_PC_OTHER) begin
              if (irq_context) begin
                main_pc_next = stage.data;
              end else begin
                irq_start_next = stage.data;
                irq_pc_next    = stage.data;
              end
            end
          end
        end
      end

      FUNC_INC: begin
        if (irq_context) irq_pc_next = irq_pc + 16'd1;
        else main_pc_next = main_pc + 16'd1;
      end

      FUNC_END: begin
        irq_context_next = stage.irq_pending && (irq_start != '0);
        if (!irq_context_next) irq_pc_next = irq_start;
        if (stage.move_source == '0 && stage.move_dest == '0) begin
          if (blank_count != BLANK_LIMIT) blank_count_next = blank_count + 2'd1;
          if (blank_count_next == BLANK_LIMIT) res_next.fault = FAULT_BLANK_MOVE;
        end else begin
          blank_count_next = '0;
        end
        // odd PC is checked after the context switch
        if (res_next.fault == FAULT_NONE &&
            (irq_context_next ? irq_pc_next[0] : main_pc_next[0])) begin
          res_next.fault = FAULT_ODD_PC;
        end
      end
    endcase

    res_next.current_pc   = irq_context_next ? irq_pc_next : main_pc_next;
    res_next.in_interrupt = irq_context_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) stage <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_free) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_a     <= '0;
      operand_b     <= '0;
      alu_op        <= '0;
      main_pc       <= '0;
      irq_pc        <= '0;
      irq_start     <= '0;
      irq_context   <= 1'b0;
      page_length   <= '0;
      page_source   <= '0;
      guard_on_main <= 1'b0;
      guard_on_irq  <= 1'b0;
      blank_count   <= '0;
    end else if (advance) begin
      operand_a     <= operand_a_next;
      operand_b     <= operand_b_next;
      alu_op        <= alu_op_next;
      main_pc       <= main_pc_next;
      irq_pc        <= irq_pc_next;
      irq_start     <= irq_start_next;
      irq_context   <= irq_context_next;
      page_length   <= page_length_next;
      page_source   <= page_source_next;
      guard_on_main <= guard_on_main_next;
      guard_on_irq  <= guard_on_irq_next;
      blank_count   <= blank_count_next;
    end
  end

  `MMSR_ASSERT_NEXT(a_advance_fills_result, clk, rst, advance, result_valid)
  `MMSR_ASSERT(a_no_data_without_valid, clk, rst,
    !(result_valid && !result.read_valid && result.read_data != '0))
  `MMSR_ASSERT(a_blank_fault_is_move_end, clk, rst,
    !(result_valid && result.fault == FAULT_BLANK_MOVE &&
      (result.blocked || result.read_valid || result.mapped_address != '0)))
  `MMSR_ASSERT_NEXT(a_blank_count_saturates, clk, rst,
    advance && stage.func == FUNC_END && blank_count == BLANK_LIMIT &&
      stage.move_source == '0 && stage.move_dest == '0,
    blank_count == BLANK_LIMIT && result.fault == FAULT_BLANK_MOVE)

endmodule

`default_nettype wire
